FILE: src/grs_pkg.sv
// Shared types and constants of the Gaussian radial symmetry term pipeline.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package grs_pkg;

   // Number formats.
   localparam int WORD_BITS    = 32;
   localparam int FRAC_BITS    = 16;
   localparam int GAUSS_BITS   = 16;
   localparam int REG_BITS     = 31;
   localparam int LANES        = 3;

   // Iterative units unrolled into pipeline stages.
   localparam int SQRT_BITS     = 32;
   localparam int QUOT_BITS     = 32;
   localparam int EXP_BITS      = 6;
   localparam int SERIES_TERMS  = 12;
   localparam int SERIES_STAGES = 3 * SERIES_TERMS;
   localparam int RECIP_SHIFT   = 36;
   localparam int N_LIMIT       = 40;

   // ln(2) in Q32.
   localparam logic [31:0] LN2_Q32 = 32'hB172_17F8;

   // floor(2^36 / k) for the Taylor term divisions. For k = 1 the value does not
   // fit, so the largest 36-bit value stands in and the correction step adds the one.
   localparam logic [35:0] RECIP [1:SERIES_TERMS] = '{
      36'hF_FFFF_FFFF,
      36'd34359738368,
      36'd22906492245,
      36'd17179869184,
      36'd13743895347,
      36'd11453246122,
      36'd9817068105,
      36'd8589934592,
      36'd7635497415,
      36'd6871947673,
      36'd6247225157,
      36'd5726623061
   };

   typedef logic [WORD_BITS-1:0] word_type;

   // Configuration register indexes.
   typedef enum logic [0:0] {
      CSR_CENTER = 1'b0,
      CSR_WIDTH  = 1'b1
   } csr_index_type;

   // Everything one transaction carries down the pipeline.
   typedef struct packed {
      logic                       wneg;
      logic [LANES-1:0]           sneg;
      word_type                   wmag;
      logic [LANES-1:0][31:0]     smag;
      logic [LANES-1:0][63:0]     sqp;
      logic [63:0]                sq;
      logic [31:0]                d;
      logic                       dneg;
      logic [31:0]                dmag;
      logic [63:0]                sqd;
      logic [62:0]                pl;
      logic [62:0]                ph;
      logic [37:0]                a;
      logic [EXP_BITS-1:0]        n;
      logic [31:0]                x;
      logic [31:0]                q0;
      logic [32:0]                term;
      logic signed [35:0]         sum;
      logic [32:0]                e;
      logic [GAUSS_BITS:0]        g;
      logic [48:0]                wg;
      logic [31:0]                m;
      word_type                   value_term;
      logic [LANES-1:0][63:0]     ms;
      logic [LANES-1:0][31:0]     q;
      logic [LANES-1:0][62:0]     t;
      logic [LANES-1:0][64:0]     ulo;
      logic [LANES-1:0][63:0]     uhi;
   } item_type;

endpackage

FILE: src/gaussian_radial_symmetry_term.sv
// Top level of the Gaussian radial symmetry term pipeline.
// Depends on grs_pkg, grs_isqrt and grs_div.
`timescale 1ns / 1ps

// Computes, for one neighbor pair per transaction, the Gaussian factor
// g = exp(-nu*(d-center)^2) of the separation length d, the value term g*weight,
// the weight derivative g and the saturated vector derivative, all in Q16.16 except
// g in Q1.16. The block is a fully pipelined datapath: it accepts one transaction
// every clock cycle while the pipeline is not stalled and returns the results in order.
// The pipeline holds the 32-stage square root, the 6-stage range reduction,
// the 36-stage Taylor series for the exponential and the 32-stage divider.
// When the result register is held by the consumer the whole pipeline stalls, and
// the input stage still takes one transaction if it is empty. Write gauss_center
// and gauss_width only while no transaction is in flight.
module gaussian_radial_symmetry_term (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  logic signed [31:0]  req_weight,
   input  logic signed [31:0]  req_sep_x,
   input  logic signed [31:0]  req_sep_y,
   input  logic signed [31:0]  req_sep_z,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output logic signed [31:0]  rsp_value_term,
   output logic [16:0]         rsp_weight_deriv,
   output logic signed [31:0]  rsp_deriv_x,
   output logic signed [31:0]  rsp_deriv_y,
   output logic signed [31:0]  rsp_deriv_z,
   output logic                rsp_zero_length,
   input  logic                csr_we,
   input  logic [0:0]          csr_index,
   input  logic [30:0]         csr_wdata
);

   localparam int NL = grs_pkg::LANES;

   // Configuration registers.
   logic [grs_pkg::REG_BITS-1:0] center_ff;
   logic [grs_pkg::REG_BITS-1:0] width_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         center_ff <= '0;
         width_ff  <= grs_pkg::REG_BITS'(1 << grs_pkg::FRAC_BITS);
      end else if (csr_we) begin
         unique case (csr_index)
            grs_pkg::CSR_CENTER: center_ff <= csr_wdata;
            grs_pkg::CSR_WIDTH:  width_ff  <= csr_wdata;
            default: ;
         endcase
      end
   end

   // Pipeline advance: everything moves when the result register is free or taken.
   logic out_valid_ff;
   logic adv;
   logic v0_ff;

   assign adv       = !out_valid_ff || rsp_ready;
   assign req_ready = adv || !v0_ff;

   // Input stage.
   grs_pkg::word_type        w0_ff;
   logic [NL-1:0][31:0]      sep0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
      end else if (req_ready) begin
         v0_ff <= req_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         w0_ff      <= req_weight;
         sep0_ff[0] <= req_sep_x;
         sep0_ff[1] <= req_sep_y;
         sep0_ff[2] <= req_sep_z;
      end
   end

   // Stage registers of the fixed part of the datapath.
   grs_pkg::item_type s1_ff, s2_ff, s3_ff, s4_ff, s5_ff, s6_ff, s7_ff;
   grs_pkg::item_type s8_ff, s9_ff, s10_ff, s11_ff, s12_ff, s13_ff, s14_ff;
   grs_pkg::item_type s1_in, s2_in, s3_in, s4_in, s5_in, s6_in, s7_in;
   grs_pkg::item_type s8_in, s9_in, s10_in, s11_in, s12_in, s13_in, s14_in;
   logic v1_ff, v2_ff, v3_ff, v4_ff, v5_ff, v6_ff, v7_ff;
   logic v8_ff, v9_ff, v10_ff, v11_ff, v12_ff, v13_ff, v14_ff;

   grs_pkg::item_type sqrt_item, div_item;
   logic              sqrt_valid, div_valid;

   // Sign and magnitude of every input word.
   always_comb begin
      s1_in      = '0;
      s1_in.wneg = w0_ff[31];
      s1_in.wmag = w0_ff[31] ? ~w0_ff + 32'd1 : w0_ff;
      for (int l = 0; l < NL; l++) begin
         s1_in.sneg[l] = sep0_ff[l][31];
         s1_in.smag[l] = sep0_ff[l][31] ? ~sep0_ff[l] + 32'd1 : sep0_ff[l];
      end
   end

   // Squares of the components.
   always_comb begin
      s2_in = s1_ff;
      for (int l = 0; l < NL; l++) begin
         s2_in.sqp[l] = 64'(s1_ff.smag[l]) * 64'(s1_ff.smag[l]);
      end
   end

   // Squared length.
   always_comb begin
      s3_in    = s2_ff;
      s3_in.sq = s2_ff.sqp[0] + s2_ff.sqp[1] + s2_ff.sqp[2];
   end

   grs_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v3_ff),
      .in_item   (s3_ff),
      .out_valid (sqrt_valid),
      .out_item  (sqrt_item)
   );

   // Distance from the Gaussian center.
   always_comb begin
      s4_in      = sqrt_item;
      s4_in.dneg = sqrt_item.d < {1'b0, center_ff};
      s4_in.dmag = s4_in.dneg ? {1'b0, center_ff} - sqrt_item.d
                              : sqrt_item.d - {1'b0, center_ff};
   end

   always_comb begin
      s5_in     = s4_ff;
      s5_in.sqd = 64'(s4_ff.dmag) * 64'(s4_ff.dmag);
   end

   // nu times the squared distance, as two partial products.
   always_comb begin
      s6_in    = s5_ff;
      s6_in.pl = 63'(s5_ff.sqd[31:0]) * 63'(width_ff);
      s6_in.ph = 63'(s5_ff.sqd[63:32]) * 63'(width_ff);
   end

   // Exponent argument in Q32, clamped at 32.0; the series starts at 1.0.
   always_comb begin
      logic [94:0] p;
      p = {s6_ff.ph, 32'b0} + 95'(s6_ff.pl);
      s7_in      = s6_ff;
      s7_in.a    = (|p[94:3*grs_pkg::FRAC_BITS+5]) ? 38'h20_0000_0000
                                                   : {1'b0, p[52:16]};
      s7_in.n    = '0;
      s7_in.term = 33'h1_0000_0000;
      s7_in.sum  = 36'sh1_0000_0000;
   end

   // Range reduction: n = floor(a / ln2), remainder left in a.
   grs_pkg::item_type nd_chain  [grs_pkg::EXP_BITS+1];
   logic              nd_vchain [grs_pkg::EXP_BITS+1];

   assign nd_chain[0]  = s7_ff;
   assign nd_vchain[0] = v7_ff;

   for (genvar i = 0; i < grs_pkg::EXP_BITS; i++) begin : g_ndiv
      localparam int B = grs_pkg::EXP_BITS - 1 - i;
      localparam logic [37:0] STEP = 38'(grs_pkg::LN2_Q32) << B;

      grs_pkg::item_type nd_ff;
      grs_pkg::item_type nd_in;
      logic              nd_v_ff;

      always_comb begin
         nd_in = nd_chain[i];
         if (nd_chain[i].a >= STEP) begin
            nd_in.a    = nd_chain[i].a - STEP;
            nd_in.n[B] = 1'b1;
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            nd_v_ff <= 1'b0;
         end else if (adv) begin
            nd_v_ff <= nd_vchain[i];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nd_ff <= nd_in;
         end
      end

      assign nd_chain[i+1]  = nd_ff;
      assign nd_vchain[i+1] = nd_v_ff;
   end

   // Taylor series of exp(-r), three stages per term: multiply, reciprocal, correct.
   grs_pkg::item_type ty_chain  [grs_pkg::SERIES_STAGES+1];
   logic              ty_vchain [grs_pkg::SERIES_STAGES+1];

   assign ty_chain[0]  = nd_chain[grs_pkg::EXP_BITS];
   assign ty_vchain[0] = nd_vchain[grs_pkg::EXP_BITS];

   for (genvar j = 0; j < grs_pkg::SERIES_STAGES; j++) begin : g_series
      localparam int K  = j / 3 + 1;
      localparam int PH = j % 3;

      grs_pkg::item_type ty_ff;
      grs_pkg::item_type ty_in;
      logic              ty_v_ff;

      if (PH == 0) begin : g_mul
         // term * r in Q32.
         always_comb begin
            logic [64:0] prod;
            prod    = 65'(ty_chain[j].term) * 65'(ty_chain[j].a[31:0]);
            ty_in   = ty_chain[j];
            ty_in.x = prod[63:32];
         end
      end else if (PH == 1) begin : g_recip
         // Quotient estimate, at most one below the true quotient.
         always_comb begin
            logic [67:0] prod;
            prod     = 68'(ty_chain[j].x) * 68'(grs_pkg::RECIP[K]);
            ty_in    = ty_chain[j];
            ty_in.q0 = prod[67:grs_pkg::RECIP_SHIFT];
         end
      end else begin : g_fix
         // Correct the estimate and add the term with alternating sign.
         always_comb begin
            logic [35:0] qk;
            logic [31:0] rem;
            logic [32:0] nterm;
            qk    = 36'(ty_chain[j].q0) * 36'(K);
            rem   = ty_chain[j].x - qk[31:0];
            nterm = {1'b0, ty_chain[j].q0} + 33'(rem >= 32'(K));
            ty_in      = ty_chain[j];
            ty_in.term = nterm;
            if (K % 2 == 1) begin
               ty_in.sum = ty_chain[j].sum - $signed({3'b0, nterm});
            end else begin
               ty_in.sum = ty_chain[j].sum + $signed({3'b0, nterm});
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            ty_v_ff <= 1'b0;
         end else if (adv) begin
            ty_v_ff <= ty_vchain[j];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            ty_ff <= ty_in;
         end
      end

      assign ty_chain[j+1]  = ty_ff;
      assign ty_vchain[j+1] = ty_v_ff;
   end

   // Clamp the series sum to [0, 1.0].
   always_comb begin
      s8_in = ty_chain[grs_pkg::SERIES_STAGES];
      if (s8_in.sum[35]) begin
         s8_in.e = '0;
      end else if (s8_in.sum[34:0] > 35'h1_0000_0000) begin
         s8_in.e = 33'h1_0000_0000;
      end else begin
         s8_in.e = s8_in.sum[32:0];
      end
   end

   // Scale by 2^-n with rounding to Q1.16.
   always_comb begin
      logic [55:0] tmp;
      logic [6:0]  sh;
      sh    = 7'(s8_ff.n) + 7'(grs_pkg::GAUSS_BITS - 1);
      tmp   = 56'(s8_ff.e) + (56'd1 << sh);
      s9_in = s8_ff;
      if (s8_ff.n >= grs_pkg::EXP_BITS'(grs_pkg::N_LIMIT)) begin
         s9_in.g = '0;
      end else begin
         s9_in.g = 17'(tmp >> (sh + 7'd1));
      end
   end

   always_comb begin
      s10_in    = s9_ff;
      s10_in.wg = 49'(s9_ff.wmag) * 49'(s9_ff.g);
   end

   // Rounded |w|*g and the saturated value term.
   always_comb begin
      logic [49:0] rnd;
      logic [31:0] vlim;
      logic [31:0] vm;
      rnd    = 50'(s10_ff.wg) + 50'(1 << (grs_pkg::GAUSS_BITS - 1));
      s11_in = s10_ff;
      s11_in.m = rnd[grs_pkg::GAUSS_BITS+31:grs_pkg::GAUSS_BITS];
      vlim   = s10_ff.wneg ? 32'h8000_0000 : 32'h7FFF_FFFF;
      vm     = (s11_in.m > vlim) ? vlim : s11_in.m;
      s11_in.value_term = s10_ff.wneg ? ~vm + 32'd1 : vm;
   end

   // Dividends m * |s| for the three lanes.
   always_comb begin
      s12_in   = s11_ff;
      s12_in.q = '0;
      for (int l = 0; l < NL; l++) begin
         s12_in.ms[l] = 64'(s11_ff.m) * 64'(s11_ff.smag[l]);
      end
   end

   grs_div u_div (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (v12_ff),
      .in_item   (s12_ff),
      .out_valid (div_valid),
      .out_item  (div_item)
   );

   always_comb begin
      s13_in = div_item;
      for (int l = 0; l < NL; l++) begin
         s13_in.t[l] = 63'(div_item.q[l]) * 63'(width_ff);
      end
   end

   // Times 2*|d - center|, split into two partial products.
   always_comb begin
      logic [32:0] dm2;
      dm2    = {s13_ff.dmag, 1'b0};
      s14_in = s13_ff;
      for (int l = 0; l < NL; l++) begin
         s14_in.ulo[l] = 65'(s13_ff.t[l][31:0]) * 65'(dm2);
         s14_in.uhi[l] = 64'(s13_ff.t[l][62:32]) * 64'(dm2);
      end
   end

   // Final rounding, saturation and sign of the vector derivative.
   logic [NL-1:0][31:0] deriv_in;

   always_comb begin
      logic [65:0] lor;
      logic [64:0] res;
      logic        neg;
      logic [31:0] lim;
      logic [31:0] mag;
      for (int l = 0; l < NL; l++) begin
         lor = 66'(s14_ff.ulo[l]) + (66'(1) << (2*grs_pkg::FRAC_BITS - 1));
         res = 65'(s14_ff.uhi[l]) + 65'(lor[65:2*grs_pkg::FRAC_BITS]);
         neg = !(s14_ff.wneg ^ s14_ff.dneg ^ s14_ff.sneg[l]);
         lim = neg ? 32'h8000_0000 : 32'h7FFF_FFFF;
         mag = (res > 65'(lim)) ? lim : res[31:0];
         if (s14_ff.d == '0) begin
            deriv_in[l] = '0;
         end else begin
            deriv_in[l] = neg ? ~mag + 32'd1 : mag;
         end
      end
   end

   // Valid bits of the fixed stages.
   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff  <= 1'b0;
         v2_ff  <= 1'b0;
         v3_ff  <= 1'b0;
         v4_ff  <= 1'b0;
         v5_ff  <= 1'b0;
         v6_ff  <= 1'b0;
         v7_ff  <= 1'b0;
         v8_ff  <= 1'b0;
         v9_ff  <= 1'b0;
         v10_ff <= 1'b0;
         v11_ff <= 1'b0;
         v12_ff <= 1'b0;
         v13_ff <= 1'b0;
         v14_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff  <= v0_ff;
         v2_ff  <= v1_ff;
         v3_ff  <= v2_ff;
         v4_ff  <= sqrt_valid;
         v5_ff  <= v4_ff;
         v6_ff  <= v5_ff;
         v7_ff  <= v6_ff;
         v8_ff  <= ty_vchain[grs_pkg::SERIES_STAGES];
         v9_ff  <= v8_ff;
         v10_ff <= v9_ff;
         v11_ff <= v10_ff;
         v12_ff <= v11_ff;
         v13_ff <= div_valid;
         v14_ff <= v13_ff;
         out_valid_ff <= v14_ff;
      end
   end

   // Payload of the fixed stages and the result register.
   logic [31:0]         value_term_ff;
   logic [16:0]         weight_deriv_ff;
   logic [NL-1:0][31:0] deriv_ff;
   logic                zero_length_ff;

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_ff  <= s1_in;
         s2_ff  <= s2_in;
         s3_ff  <= s3_in;
         s4_ff  <= s4_in;
         s5_ff  <= s5_in;
         s6_ff  <= s6_in;
         s7_ff  <= s7_in;
         s8_ff  <= s8_in;
         s9_ff  <= s9_in;
         s10_ff <= s10_in;
         s11_ff <= s11_in;
         s12_ff <= s12_in;
         s13_ff <= s13_in;
         s14_ff <= s14_in;
         value_term_ff   <= s14_ff.value_term;
         weight_deriv_ff <= s14_ff.g;
         deriv_ff        <= deriv_in;
         zero_length_ff  <= (s14_ff.d == '0);
      end
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_value_term   = value_term_ff;
   assign rsp_weight_deriv = weight_deriv_ff;
   assign rsp_deriv_x      = deriv_ff[0];
   assign rsp_deriv_y      = deriv_ff[1];
   assign rsp_deriv_z      = deriv_ff[2];
   assign rsp_zero_length  = zero_length_ff;

   // A zero length must force every vector derivative to zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_zero_length |->
         rsp_deriv_x == '0 && rsp_deriv_y == '0 && rsp_deriv_z == '0)
      else $error("vector derivative not zero for a zero length");

   // The Gaussian factor never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_weight_deriv <= 17'd65536)
      else $error("Gaussian factor above one");

   // A vanished Gaussian factor leaves no value term.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_weight_deriv == '0 |-> rsp_value_term == '0)
      else $error("value term without Gaussian factor");

   // The input side only stalls behind a held result and a full input stage.
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> out_valid_ff && !rsp_ready && v0_ff)
      else $error("input stalled without back pressure");

endmodule

FILE: src/grs_isqrt.sv
// Pipelined integer square root, one result bit per stage.
// Depends on grs_pkg for the transaction type and the stage count.
`timescale 1ns / 1ps

module grs_isqrt (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  grs_pkg::item_type in_item,
   output logic              out_valid,
   output grs_pkg::item_type out_item
);

   logic              v_chain    [grs_pkg::SQRT_BITS+1];
   grs_pkg::item_type it_chain   [grs_pkg::SQRT_BITS+1];
   logic [32:0]       rem_chain  [grs_pkg::SQRT_BITS+1];
   logic [31:0]       root_chain [grs_pkg::SQRT_BITS+1];

   assign v_chain[0]    = in_valid;
   assign it_chain[0]   = in_item;
   assign rem_chain[0]  = '0;
   assign root_chain[0] = '0;

   for (genvar i = 0; i < grs_pkg::SQRT_BITS; i++) begin : g_stage
      localparam int B = grs_pkg::SQRT_BITS - 1 - i;

      logic              v_ff;
      grs_pkg::item_type it_ff;
      logic [32:0]       rem_ff;
      logic [31:0]       root_ff;
      logic [32:0]       rem_in;
      logic [31:0]       root_in;
      logic [34:0]       cur;
      logic [34:0]       trial;

      // Bring down two radicand bits and try the next root bit.
      always_comb begin
         cur   = {rem_chain[i], it_chain[i].sq[2*B+1 -: 2]};
         trial = {1'b0, root_chain[i], 2'b01};
         if (cur >= trial) begin
            rem_in  = 33'(cur - trial);
            root_in = {root_chain[i][30:0], 1'b1};
         end else begin
            rem_in  = cur[32:0];
            root_in = {root_chain[i][30:0], 1'b0};
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_chain[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            it_ff   <= it_chain[i];
            rem_ff  <= rem_in;
            root_ff <= root_in;
         end
      end

      assign v_chain[i+1]    = v_ff;
      assign it_chain[i+1]   = it_ff;
      assign rem_chain[i+1]  = rem_ff;
      assign root_chain[i+1] = root_ff;
   end

   // The root joins the transaction at the last stage.
   always_comb begin
      out_item   = it_chain[grs_pkg::SQRT_BITS];
      out_item.d = root_chain[grs_pkg::SQRT_BITS];
   end

   assign out_valid = v_chain[grs_pkg::SQRT_BITS];

endmodule

FILE: src/grs_div.sv
// Pipelined restoring divider, three lanes sharing one divisor, one quotient bit per stage.
// Depends on grs_pkg for the transaction type and the stage count.
`timescale 1ns / 1ps

module grs_div (
   input  logic              clock,
   input  logic              reset,
   input  logic              en,
   input  logic              in_valid,
   input  grs_pkg::item_type in_item,
   output logic              out_valid,
   output grs_pkg::item_type out_item
);

   logic              v_chain   [grs_pkg::QUOT_BITS+1];
   grs_pkg::item_type it_chain  [grs_pkg::QUOT_BITS+1];
   logic [31:0]       rem_chain [grs_pkg::QUOT_BITS+1][grs_pkg::LANES];

   assign v_chain[0]  = in_valid;
   assign it_chain[0] = in_item;
   for (genvar l = 0; l < grs_pkg::LANES; l++) begin : g_init
      // The upper half of the dividend is already below the divisor.
      assign rem_chain[0][l] = in_item.ms[l][63:32];
   end

   for (genvar i = 0; i < grs_pkg::QUOT_BITS; i++) begin : g_stage
      localparam int B = grs_pkg::QUOT_BITS - 1 - i;

      logic              v_ff;
      grs_pkg::item_type it_ff;
      grs_pkg::item_type it_in;
      logic [31:0]       rem_ff [grs_pkg::LANES];
      logic [31:0]       rem_in [grs_pkg::LANES];

      // Shift in the next dividend bit and subtract where it fits.
      always_comb begin
         it_in = it_chain[i];
         for (int l = 0; l < grs_pkg::LANES; l++) begin
            if ({rem_chain[i][l], it_chain[i].ms[l][B]} >= {1'b0, it_chain[i].d}) begin
               rem_in[l]      = 32'({rem_chain[i][l], it_chain[i].ms[l][B]}
                                    - {1'b0, it_chain[i].d});
               it_in.q[l][B]  = 1'b1;
            end else begin
               rem_in[l]      = {rem_chain[i][l][30:0], it_chain[i].ms[l][B]};
            end
         end
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff <= 1'b0;
         end else if (en) begin
            v_ff <= v_chain[i];
         end
      end

      always_ff @(posedge clock) begin
         if (en) begin
            it_ff  <= it_in;
            rem_ff <= rem_in;
         end
      end

      assign v_chain[i+1]   = v_ff;
      assign it_chain[i+1]  = it_ff;
      assign rem_chain[i+1] = rem_ff;
   end

   assign out_valid = v_chain[grs_pkg::QUOT_BITS];
   assign out_item  = it_chain[grs_pkg::QUOT_BITS];

endmodule

FILE: tb/testbench.sv
// Self-checking testbench for the Gaussian radial symmetry term pipeline.
// Depends on grs_pkg and the gaussian_radial_symmetry_term RTL.
`timescale 1ns / 1ps

module testbench;

   localparam int LATENCY     = 122;
   localparam int CYCLE_LIMIT = 2000000;
   localparam int SHOWN_ERRORS = 10;

   // One result of the block, one field per port.
   typedef struct {
      logic [31:0] value_term;
      logic [16:0] weight_deriv;
      logic [31:0] deriv_x;
      logic [31:0] deriv_y;
      logic [31:0] deriv_z;
      logic        zero_length;
   } pair_terms_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [31:0] req_weight, req_sep_x, req_sep_y, req_sep_z;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [31:0] rsp_value_term, rsp_deriv_x, rsp_deriv_y, rsp_deriv_z;
   logic [16:0] rsp_weight_deriv;
   logic        rsp_zero_length;
   logic        csr_we;
   logic [0:0]  csr_index;
   logic [30:0] csr_wdata;

   // Local copy of the two registers, updated with every write.
   logic [63:0] center_reg;
   logic [63:0] width_reg;

   pair_terms_type pending_terms[$];
   int          mismatches;
   int          results_seen;
   int          cycle_count;
   int          stall_left;
   bit          quiet_mode;

   gaussian_radial_symmetry_term i_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_weight       (req_weight),
      .req_sep_x        (req_sep_x),
      .req_sep_y        (req_sep_y),
      .req_sep_z        (req_sep_z),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_value_term   (rsp_value_term),
      .rsp_weight_deriv (rsp_weight_deriv),
      .rsp_deriv_x      (rsp_deriv_x),
      .rsp_deriv_y      (rsp_deriv_y),
      .rsp_deriv_z      (rsp_deriv_z),
      .rsp_zero_length  (rsp_zero_length),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata)
   );

   always #4 clock = ~clock;

   // Returns the magnitude of a two's complement word.
   function automatic logic [63:0] magnitude_of(logic [31:0] v);
      logic [31:0] n;
      n = ~v + 32'd1;
      return v[31] ? {32'd0, n} : {32'd0, v};
   endfunction

   // Computes the expected terms of one pair under the current registers.
   function automatic pair_terms_type predict_pair_terms(logic [31:0] w, logic [31:0] sx,
                                                        logic [31:0] sy, logic [31:0] sz);
      pair_terms_type res;
      logic [31:0]  comp[3];
      logic [63:0]  smag[3];
      logic [63:0]  wmag, d, dmag, a, n, r, term, e, g, m, lim, q;
      logic [127:0] sq, c, p, prod, quo;
      logic         dneg, neg;
      longint       sum;
      comp[0] = sx;
      comp[1] = sy;
      comp[2] = sz;
      wmag = magnitude_of(w);
      sq = '0;
      for (int i = 0; i < 3; i++) begin
         smag[i] = magnitude_of(comp[i]);
         sq = sq + {64'd0, smag[i]} * {64'd0, smag[i]};
      end
      // Exact integer square root.
      d = '0;
      for (int b = 63; b >= 0; b--) begin
         c = {64'd0, d | (64'd1 << b)};
         if (c * c <= sq) d = c[63:0];
      end
      dneg = d < center_reg;
      dmag = dneg ? center_reg - d : d - center_reg;
      // Exponent in Q32, clamped at 32.0, then range reduction by ln(2).
      p = {64'd0, dmag} * {64'd0, dmag} * {64'd0, width_reg};
      if ((p >> 53) != 0) a = 64'd1 << 37;
      else a = p[79:16];
      n = a / {32'd0, grs_pkg::LN2_Q32};
      if (n >= 40) begin
         g = 0;
      end else begin
         r = a - n * {32'd0, grs_pkg::LN2_Q32};
         term = 64'd1 << 32;
         sum = longint'(term);
         for (int k = 1; k <= 12; k++) begin
            term = ((term * r) >> 32) / k;
            if (k % 2 == 1) sum = sum - longint'(term);
            else sum = sum + longint'(term);
         end
         if (sum < 0) sum = 0;
         e = sum;
         if (e > (64'd1 << 32)) e = 64'd1 << 32;
         g = (e + (64'd1 << (15 + n))) >> (16 + n);
      end
      m = (wmag * g + 64'd32768) >> 16;
      // Value term with saturation toward the sign of the weight.
      lim = w[31] ? 64'h8000_0000 : 64'h7FFF_FFFF;
      res.value_term = (m > lim) ? lim[31:0] : m[31:0];
      if (w[31]) res.value_term = ~res.value_term + 32'd1;
      res.weight_deriv = g[16:0];
      res.zero_length = (d == 0);
      res.deriv_x = '0;
      res.deriv_y = '0;
      res.deriv_z = '0;
      if (d != 0) begin
         for (int i = 0; i < 3; i++) begin
            prod = {64'd0, m} * {64'd0, smag[i]};
            quo = prod / {64'd0, d};
            q = quo[63:0];
            p = {64'd0, q} * {64'd0, width_reg} * {64'd0, 2 * dmag};
            p = (p + (128'd1 << 31)) >> 32;
            neg = !(w[31] ^ dneg ^ comp[i][31]);
            lim = neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            q = (p > {64'd0, lim}) ? lim : p[63:0];
            if (neg) q = ~q + 64'd1;
            case (i)
               0: res.deriv_x = q[31:0];
               1: res.deriv_y = q[31:0];
               default: res.deriv_z = q[31:0];
            endcase
         end
      end
      return res;
   endfunction

   // Idle length: mostly none or short, now and then long.
   function automatic int pick_gap();
      int r;
      if (quiet_mode) return 0;
      r = $urandom_range(0, 99);
      if (r < 55) return 0;
      if (r < 90) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   // Cycle limit for a hung pipeline.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   // Random backpressure on the result channel.
   always @(posedge clock) begin
      int gap;
      if (reset || quiet_mode) begin
         rsp_ready <= 1'b1;
         stall_left <= 0;
      end else if (stall_left != 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         gap = pick_gap();
         stall_left <= gap;
         rsp_ready <= (gap == 0);
      end
   end

   // Compares each accepted result with the oldest expectation.
   always @(posedge clock) begin
      pair_terms_type exp_terms;
      if (!reset && rsp_valid && rsp_ready) begin
         results_seen <= results_seen + 1;
         if (pending_terms.size() == 0) begin
            mismatches++;
            if (mismatches <= SHOWN_ERRORS)
               $display("Unexpected result transaction at cycle %0d", cycle_count);
         end else begin
            exp_terms = pending_terms.pop_front();
            if (rsp_value_term !== exp_terms.value_term ||
                rsp_weight_deriv !== exp_terms.weight_deriv ||
                rsp_deriv_x !== exp_terms.deriv_x ||
                rsp_deriv_y !== exp_terms.deriv_y ||
                rsp_deriv_z !== exp_terms.deriv_z ||
                rsp_zero_length !== exp_terms.zero_length) begin
               mismatches++;
               if (mismatches <= SHOWN_ERRORS) begin
                  $display("Mismatch on result %0d:", results_seen);
                  $display("  value %h/%h gauss %h/%h zero %b/%b", exp_terms.value_term,
                           rsp_value_term, exp_terms.weight_deriv, rsp_weight_deriv,
                           exp_terms.zero_length, rsp_zero_length);
                  $display("  deriv %h %h %h / %h %h %h", exp_terms.deriv_x,
                           exp_terms.deriv_y, exp_terms.deriv_z, rsp_deriv_x,
                           rsp_deriv_y, rsp_deriv_z);
               end
            end
         end
      end
   end

   // Sends one pair transaction and records its expected terms on acceptance.
   task automatic send_pair(logic [31:0] w, logic [31:0] sx, logic [31:0] sy,
                            logic [31:0] sz);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid  <= 1'b1;
      req_weight <= w;
      req_sep_x  <= sx;
      req_sep_y  <= sy;
      req_sep_z  <= sz;
      do @(posedge clock); while (!req_ready);
      pending_terms.push_back(predict_pair_terms(w, sx, sy, sz));
   endtask

   // Drains the pipeline, then writes one register.
   task automatic write_register(grs_pkg::csr_index_type idx, logic [30:0] value);
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_terms.size() != 0) @(posedge clock);
      repeat (LATENCY + 8) @(posedge clock);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (idx == grs_pkg::CSR_CENTER) center_reg = {33'd0, value};
      else width_reg = {33'd0, value};
   endtask

   task automatic set_gauss(logic [30:0] center, logic [30:0] width);
      write_register(grs_pkg::CSR_CENTER, center);
      write_register(grs_pkg::CSR_WIDTH, width);
   endtask

   // A separation component: mostly a few units, sometimes any word.
   function automatic logic [31:0] random_component();
      int r;
      r = $urandom_range(0, 99);
      if (r < 8) return '0;
      if (r < 75) return $urandom_range(0, 8 << 16) - (4 << 16);
      return $urandom;
   endfunction

   // Extremes of every field, zero length, saturation and underflow.
   task automatic test_directed();
      send_pair(32'h0001_0000, 32'h0, 32'h0, 32'h0);
      send_pair(32'h7FFF_FFFF, 32'h0, 32'h0, 32'h0);
      send_pair(32'h8000_0000, 32'h0, 32'h0, 32'h0);
      send_pair(32'h7FFF_FFFF, 32'h0000_8000, 32'h0, 32'h0);
      send_pair(32'h8000_0000, 32'h0, 32'hFFFF_8000, 32'h0);
      send_pair(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'h0001_0000);
      send_pair(32'hFFFF_FFFF, 32'h0000_0001, 32'hFFFF_FFFF, 32'h0000_0001);
      send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_pair(32'h0, 32'h0002_0000, 32'h0, 32'h0);
      send_pair(32'h7FFF_FFFF, 32'h0000_0100, 32'h0000_0200, 32'hFFFF_FF00);
      set_gauss(31'h0001_0000, 31'h7FFF_FFFF);
      // Large width: near the center the derivative saturates, away from it g vanishes.
      send_pair(32'h7FFF_FFFF, 32'h0001_0001, 32'h0, 32'h0);
      send_pair(32'h8000_0000, 32'h0000_FFF0, 32'h0, 32'h0);
      send_pair(32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 32'h0);
      send_pair(32'h7FFF_FFFF, 32'h0005_0000, 32'h0, 32'h0);
      send_pair(32'h0001_0000, 32'h0, 32'h0, 32'h0);
      set_gauss(31'h7FFF_FFFF, 31'h0);
      send_pair(32'h7FFF_FFFF, 32'h0001_0000, 32'h0, 32'h0);
      send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0);
      send_pair(32'h1234_5678, 32'h0, 32'h0, 32'h0);
   endtask

   // Random pairs under one register setting.
   task automatic test_random_pairs(int count);
      logic [31:0] w;
      for (int i = 0; i < count; i++) begin
         w = ($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 8 << 16) - (4 << 16);
         send_pair(w, random_component(), random_component(), random_component());
      end
   endtask

   // Walks through several register settings, extremes included.
   task automatic test_settings();
      set_gauss(31'h0, 31'h0001_0000);
      test_random_pairs(350);
      set_gauss(31'h0002_0000, 31'h0000_4000);
      quiet_mode = 1'b1;
      test_random_pairs(200);
      quiet_mode = 1'b0;
      test_random_pairs(150);
      set_gauss(31'h0003_8000, 31'h0002_0000);
      test_random_pairs(350);
      set_gauss(31'h7FFF_FFFF, 31'h7FFF_FFFF);
      test_random_pairs(150);
      set_gauss(31'h0001_8000, 31'h0000_0100);
      test_random_pairs(300);
      set_gauss(31'($urandom), 31'($urandom_range(0, 1 << 18)));
      test_random_pairs(330);
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_weight  <= '0;
      req_sep_x   <= '0;
      req_sep_y   <= '0;
      req_sep_z   <= '0;
      csr_we      <= 1'b0;
      csr_index   <= grs_pkg::CSR_CENTER;
      csr_wdata   <= '0;
      center_reg  = 64'd0;
      width_reg   = 64'd65536;
      mismatches  = 0;
      results_seen = 0;
      cycle_count = 0;
      quiet_mode  = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_settings();
      req_valid <= 1'b0;
      while (pending_terms.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);
      if (mismatches == 0 && pending_terms.size() == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
